>>> rtl/gso_pkg.sv
// Package for the Gram-Schmidt orthonormalizer: constants, codes and shared types.
// No dependencies.
`timescale 1ns / 1ps
package gso_pkg;
  localparam int unsigned MaxDim      = 64;
  localparam int unsigned MaxElements = 1024;

  localparam logic [1:0] ModeWrite = 2'd0;
  localparam logic [1:0] ModeRun   = 2'd1;
  localparam logic [1:0] ModeRead  = 2'd2;
  localparam logic [1:0] ModeNop   = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StZeroNorm = 2'd1;
  localparam logic [1:0] StBadSize  = 2'd2;
  localparam logic [1:0] StBadIndex = 2'd3;

  localparam logic [1:0] CfgRowLen   = 2'd0;
  localparam logic [1:0] CfgRowCount = 2'd1;
  localparam logic [1:0] CfgLayout   = 2'd2;

  // request from the sequencer to the arithmetic unit
  typedef struct packed {
    logic        start;
    logic [2:0]  op;
  } gso_req_t;

  localparam logic [2:0] OpSqrt = 3'd0;
  localparam logic [2:0] OpDiv  = 3'd1;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7fffffff;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction
endpackage

>>> rtl/gso_sqrt.sv
// Iterative integer square root of a 64-bit value; start restarts it, even while busy.
// No dependencies.
`timescale 1ns / 1ps
module gso_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  logic [63:0] rem_q, rem_d, res_q, res_d, bit_q, bit_d;
  logic        busy_q, busy_d, done_q, done_d;

  always_comb begin
    rem_d = rem_q; res_d = res_q; bit_d = bit_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      rem_d = x_i; res_d = '0; bit_d = 64'h4000_0000_0000_0000; busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= res_q + bit_q) begin
        rem_d = rem_q - (res_q + bit_q);
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; res_q <= res_d; bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];
endmodule

>>> rtl/gso_div.sv
// Restoring divider: (x * 2^24) / norm truncated toward zero, saturated to 32 bits.
// Depends on gso_pkg.
`timescale 1ns / 1ps
module gso_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] x_i,
  input  logic [31:0]        d_i,
  output logic               done_o,
  output logic signed [31:0] q_o
);
  logic [55:0] num_q, num_d, quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q;
  logic        neg_q, busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] trial;
  logic signed [65:0] sq;

  always_comb begin
    num_d = num_q; quo_d = quo_q; rem_d = rem_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0; trial = '0;
    if (start_i) begin
      num_d = {(x_i[31] ? 32'(-x_i) : 32'(x_i)), 24'd0};
      rem_d = '0; quo_d = '0; cnt_d = 6'd55; busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q[31:0], num_q[55]};
      num_d = num_q << 1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q}; quo_d = {quo_q[54:0], 1'b1};
      end else begin
        rem_d = trial; quo_d = {quo_q[54:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d;
    end
  end
  always_ff @(posedge clk_i) begin
    num_q <= num_d; quo_q <= quo_d; rem_q <= rem_d; cnt_q <= cnt_d;
    if (start_i) begin
      den_q <= d_i; neg_q <= x_i[31];
    end
  end

  assign sq = neg_q ? -$signed({10'd0, quo_q}) : $signed({10'd0, quo_q});
  assign q_o = gso_pkg::sat32(sq);
  assign done_o = done_q;
endmodule

>>> rtl/gram_schmidt_orthonormalizer_core.sv
// Top level of the Gram-Schmidt orthonormalizer: matrix memory and run sequencer.
// Depends on gso_pkg, gso_sqrt and gso_div.
`timescale 1ns / 1ps
// A write, or a command that is rejected or unused, passes the accept state and then the
// done state, which raises its result strobe; a read has a memory read state between
// them. A run walks the memory through one read port: a dot product for each earlier
// vector and its update pass (two reads, a multiply and a write back per element), then
// the norm sum, the square root and a division of each element. The result strobe lasts
// one cycle and the receiver cannot stall it; busy falls in the strobe cycle, so the next
// command can be accepted at the edge that ends it. The memory has no reset: read only
// entries written.
module gram_schmidt_orthonormalizer_core #(
  parameter int unsigned MAX_DIM      = gso_pkg::MaxDim,
  parameter int unsigned MAX_ELEMENTS = gso_pkg::MaxElements
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode_i,
  input  logic [9:0]         index_i,
  input  logic signed [31:0] value_i,
  output logic               done_o,
  output logic signed [31:0] read_value_o,
  output logic [1:0]         status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [6:0]         cfg_data_i
);
  localparam int unsigned AW = $clog2(MAX_ELEMENTS);

  localparam logic [3:0] SIdle = 4'd0, SAcc = 4'd1, SRdOne = 4'd2, SDot = 4'd3,
                         SUpdR = 4'd4, SUpdW = 4'd5, SNorm = 4'd6, SSqrt = 4'd7,
                         SDivR = 4'd8, SDivW = 4'd9, SDivWait = 4'd10, SDone = 4'd11,
                         SDotFin = 4'd12, SUpdM = 4'd13;

  logic [6:0] row_len_q, row_count_q;
  logic       layout_q;
  logic [31:0] mem [MAX_ELEMENTS];
  logic [31:0] rdata_q;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata;

  logic [3:0] st_q, st_d;
  logic [6:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [1:0] mode_q;
  logic [9:0] idx_q;
  logic [31:0] val_q;
  logic [1:0] stat_q, stat_d;
  logic [31:0] rv_q, rv_d;
  logic        done_q, done_d, zero_q, zero_d;
  logic signed [63:0] acc_q, acc_d;
  logic [63:0] sq_q, sq_d;
  logic signed [31:0] dot_q, dot_d, xi_q, xi_d;
  logic [31:0] norm_q, norm_d;
  logic        phase_q, phase_d; // in the dot pass, reading vector i (0) or j (1) element
  logic        pend_q, pend_d;   // read data valid next cycle
  logic signed [63:0] prod_q;
  logic        prod_v_q;
  gso_pkg::gso_req_t req;

  logic [6:0] nvec, vlen;
  logic [13:0] total;
  logic size_ok;
  logic sqrt_done, div_done;
  logic [31:0] root;
  logic signed [31:0] quo;

  assign nvec = layout_q ? row_len_q : row_count_q;
  assign vlen = layout_q ? row_count_q : row_len_q;
  assign total = row_len_q * row_count_q;
  assign size_ok = row_len_q != 0 && row_count_q != 0 && 32'(row_len_q) <= MAX_DIM &&
                   32'(row_count_q) <= MAX_DIM && 32'(total) <= MAX_ELEMENTS;

  function automatic logic [AW-1:0] pos(input logic [6:0] v, input logic [6:0] k,
                                        input logic lay, input logic [6:0] rl);
    logic [13:0] p;
    p = lay ? k * rl + 14'(v) : v * rl + 14'(k);
    return p[AW-1:0];
  endfunction

  assign cfg_ready_o = st_q == SIdle;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q <= 7'd64; row_count_q <= 7'd16; layout_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        gso_pkg::CfgRowLen:   row_len_q <= cfg_data_i;
        gso_pkg::CfgRowCount: row_count_q <= cfg_data_i;
        gso_pkg::CfgLayout:   layout_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // one multiplier, registered; fed from read data, the held element and the held dot
  logic signed [31:0] ma, mb;
  logic               mv;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) prod_v_q <= 1'b0;
    else prod_v_q <= mv;
  end
  // hold the product until the next issue
  always_ff @(posedge clk_i) begin
    if (mv) prod_q <= 64'(ma) * 64'(mb);
  end

  gso_sqrt u_sqrt (.clk_i, .rst_ni, .start_i(req.start && req.op == gso_pkg::OpSqrt),
                   .x_i(sq_q), .done_o(sqrt_done), .root_o(root));
  gso_div u_div (.clk_i, .rst_ni, .start_i(req.start && req.op == gso_pkg::OpDiv),
                 .x_i(xi_q), .d_i(norm_q), .done_o(div_done), .q_o(quo));

  logic signed [64:0] sum65;
  logic [64:0] usum;
  logic signed [65:0] tmp;

  always_comb begin
    st_d = st_q; i_d = i_q; j_d = j_q; k_d = k_q; stat_d = stat_q; rv_d = rv_q;
    done_d = 1'b0; zero_d = zero_q; acc_d = acc_q; sq_d = sq_q; dot_d = dot_q;
    xi_d = xi_q; norm_d = norm_q; phase_d = phase_q; pend_d = 1'b0;
    we = 1'b0; waddr = pos(i_q, k_q, layout_q, row_len_q); wdata = '0;
    raddr = idx_q[AW-1:0]; req = '0; ma = rdata_q; mb = rdata_q; mv = 1'b0;
    sum65 = '0; usum = '0; tmp = '0;
    unique case (st_q)
      SIdle: ;
      SAcc: begin
        stat_d = gso_pkg::StOk; rv_d = '0; zero_d = 1'b0;
        if (!size_ok || mode_q == gso_pkg::ModeNop) begin
          stat_d = (size_ok || mode_q == gso_pkg::ModeNop) ? gso_pkg::StOk
                                                           : gso_pkg::StBadSize;
          st_d = SDone;
        end else if (mode_q == gso_pkg::ModeRun) begin
          // the first vector has no earlier ones: go straight to its norm
          i_d = '0; j_d = '0; k_d = '0; acc_d = '0; sq_d = '0; phase_d = 1'b0;
          st_d = SNorm;
        end else if (14'(idx_q) >= total) begin
          stat_d = gso_pkg::StBadIndex; st_d = SDone;
        end else if (mode_q == gso_pkg::ModeWrite) begin
          we = 1'b1; waddr = idx_q[AW-1:0]; wdata = val_q; st_d = SDone;
        end else begin
          st_d = SRdOne;
        end
      end
      SRdOne: begin rv_d = rdata_q; st_d = SDone; end
      SDot: begin
        // alternate reads of v_i[k] and v_j[k]; multiply pairs as they land
        raddr = phase_q ? pos(j_q, k_q, layout_q, row_len_q)
                        : pos(i_q, k_q, layout_q, row_len_q);
        if (pend_q && phase_q) xi_d = rdata_q;
        if (pend_q && !phase_q) begin ma = xi_q; mb = rdata_q; mv = 1'b1; end
        if (prod_v_q) begin
          sum65 = 65'(acc_q) + 65'(prod_q);
          acc_d = (sum65 > 65'sh0_7fff_ffff_ffff_ffff) ? 64'sh7fff_ffff_ffff_ffff :
                  (sum65 < -65'sh0_8000_0000_0000_0000) ? 64'sh8000_0000_0000_0000 :
                  sum65[63:0];
        end
        if (k_q == vlen) begin
          st_d = SDotFin;
        end else begin
          pend_d = 1'b1; phase_d = !phase_q;
          if (phase_q) k_d = k_q + 7'd1;
        end
        if (k_q == vlen && pend_q) begin ma = xi_q; mb = rdata_q; mv = 1'b1; end
      end
      SDotFin: begin
        if (prod_v_q) begin
          sum65 = 65'(acc_q) + 65'(prod_q);
          acc_d = (sum65 > 65'sh0_7fff_ffff_ffff_ffff) ? 64'sh7fff_ffff_ffff_ffff :
                  (sum65 < -65'sh0_8000_0000_0000_0000) ? 64'sh8000_0000_0000_0000 :
                  sum65[63:0];
        end else begin
          dot_d = gso_pkg::sat32(66'(acc_q >>> 24));
          k_d = '0; phase_d = 1'b0; st_d = SUpdR;
        end
      end
      SUpdR: begin
        // read v_j[k] then v_i[k]
        raddr = phase_q ? pos(i_q, k_q, layout_q, row_len_q)
                        : pos(j_q, k_q, layout_q, row_len_q);
        if (!phase_q) begin phase_d = 1'b1; end
        else begin ma = rdata_q; mb = dot_q; mv = 1'b1; st_d = SUpdM; phase_d = 1'b0; end
      end
      SUpdM: begin xi_d = rdata_q; st_d = SUpdW; end
      SUpdW: begin
        tmp = 66'(xi_q) - 66'(gso_pkg::sat32(66'(prod_q >>> 24)));
        we = 1'b1; waddr = pos(i_q, k_q, layout_q, row_len_q);
        wdata = gso_pkg::sat32(tmp);
        if (k_q + 7'd1 == vlen) begin
          k_d = '0; phase_d = 1'b0; acc_d = '0;
          if (j_q + 7'd1 == i_q) begin st_d = SNorm; sq_d = '0; end
          else begin j_d = j_q + 7'd1; st_d = SDot; end
        end else begin
          k_d = k_q + 7'd1; st_d = SUpdR;
        end
      end
      SNorm: begin
        raddr = pos(i_q, k_q, layout_q, row_len_q);
        if (pend_q) begin ma = rdata_q; mb = rdata_q; mv = 1'b1; end
        if (prod_v_q) begin
          usum = 65'(sq_q) + 65'(prod_q);
          sq_d = usum[64] ? '1 : usum[63:0];
        end
        if (k_q != vlen) begin pend_d = 1'b1; k_d = k_q + 7'd1; end
        else if (!pend_q && !prod_v_q) begin
          req.start = 1'b1; req.op = gso_pkg::OpSqrt; st_d = SSqrt;
        end
      end
      SSqrt: if (sqrt_done) begin
        norm_d = root; k_d = '0; st_d = SDivR;
        if (root == '0) zero_d = 1'b1;
      end
      SDivR: begin
        raddr = pos(i_q, k_q, layout_q, row_len_q);
        st_d = SDivW;
      end
      SDivW: begin
        xi_d = rdata_q;
        if (norm_q == '0) begin
          we = 1'b1; wdata = '0; st_d = SDivWait; 
        end else begin
          st_d = SDivWait; phase_d = 1'b1;
        end
      end
      SDivWait: begin
        if (phase_q) begin req.start = 1'b1; req.op = gso_pkg::OpDiv; phase_d = 1'b0; end
        if (norm_q == '0 || (div_done && !phase_q)) begin
          if (norm_q != '0) begin we = 1'b1; wdata = quo; end
          if (k_q + 7'd1 == vlen) begin
            k_d = '0; acc_d = '0; j_d = '0;
            if (i_q + 7'd1 >= nvec) begin
              stat_d = zero_d ? gso_pkg::StZeroNorm : gso_pkg::StOk; st_d = SDone;
            end else begin
              i_d = i_q + 7'd1; st_d = SDot;
            end
          end else begin
            k_d = k_q + 7'd1; st_d = SDivR;
          end
        end
      end
      SDone: begin done_d = 1'b1; st_d = SIdle; end
      default: st_d = SIdle;
    endcase
    if (st_q == SIdle && start) st_d = SAcc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; done_q <= 1'b0; pend_q <= 1'b0;
    end else begin
      st_q <= st_d; done_q <= done_d; pend_q <= pend_d;
    end
  end
  always_ff @(posedge clk_i) begin
    if (st_q == SIdle && start) begin
      mode_q <= mode_i; idx_q <= index_i; val_q <= value_i;
    end
    i_q <= i_d; j_q <= j_d; k_q <= k_d; stat_q <= stat_d; rv_q <= rv_d;
    zero_q <= zero_d; acc_q <= acc_d; sq_q <= sq_d; dot_q <= dot_d;
    xi_q <= xi_d; norm_q <= norm_d; phase_q <= phase_d;
  end

  assign busy = st_q != SIdle;
  assign done_o = done_q;
  assign read_value_o = rv_q;
  assign status_o = stat_q;
endmodule

>>> tb/sv/gso_checker.sv
// Checker for the Gram-Schmidt orthonormalizer: watches the command, config and result
// channels, predicts each result and compares. Depends on gso_pkg.
`timescale 1ns / 1ps
module gso_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         mode_i,
  input  logic [9:0]         index_i,
  input  logic signed [31:0] value_i,
  input  logic               done_i,
  input  logic signed [31:0] read_value_i,
  input  logic [1:0]         status_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [6:0]         cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import gso_pkg::*;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
  } gso_result_t;

  localparam longint I64Max = 64'sh7fffffffffffffff;
  localparam longint I64Min = 64'sh8000000000000000;

  logic signed [31:0] mat_model [0:MaxElements-1];
  int unsigned        row_len_q;
  int unsigned        row_count_q;
  bit                 layout_q;
  gso_result_t        result_queue [$];

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic longint acc_add(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(I64Max)) return I64Max;
    if (s < 65'(I64Min)) return I64Min;
    return s[63:0];
  endfunction

  function automatic logic [31:0] root64(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  function automatic bit dims_ok();
    if (row_len_q == 0 || row_len_q > MaxDim) return 0;
    if (row_count_q == 0 || row_count_q > MaxDim) return 0;
    return row_len_q * row_count_q <= MaxElements;
  endfunction

  function automatic int unsigned addr_of(int unsigned v, int unsigned k);
    return layout_q ? k * row_len_q + v : v * row_len_q + k;
  endfunction

  // Modified Gram-Schmidt over the model store; returns 1 if a zero norm was met.
  function automatic bit orthonormalize();
    int unsigned nvec, vlen, i, j, k;
    longint      acc, x;
    logic signed [31:0] dotv, t;
    logic [63:0] sq, p;
    logic [31:0] nrm;
    bit          zero_seen;
    nvec = layout_q ? row_len_q : row_count_q;
    vlen = layout_q ? row_count_q : row_len_q;
    zero_seen = 0;
    for (i = 0; i < nvec; i++) begin
      for (j = 0; j < i; j++) begin
        acc = 0;
        for (k = 0; k < vlen; k++)
          acc = acc_add(acc, longint'(mat_model[addr_of(i, k)]) *
                             longint'(mat_model[addr_of(j, k)]));
        dotv = clamp32(acc >>> 24);
        for (k = 0; k < vlen; k++) begin
          t = clamp32((longint'(mat_model[addr_of(j, k)]) * longint'(dotv)) >>> 24);
          mat_model[addr_of(i, k)] =
            clamp32(longint'(mat_model[addr_of(i, k)]) - longint'(t));
        end
      end
      sq = '0;
      for (k = 0; k < vlen; k++) begin
        x  = mat_model[addr_of(i, k)];
        p  = x * x;
        sq = (sq > ~64'd0 - p) ? ~64'd0 : sq + p;
      end
      nrm = root64(sq);
      for (k = 0; k < vlen; k++) begin
        if (nrm == 0)
          mat_model[addr_of(i, k)] = '0;
        else
          mat_model[addr_of(i, k)] = clamp32(
            (longint'(mat_model[addr_of(i, k)]) * 64'sd16777216) / longint'({32'd0, nrm}));
      end
      if (nrm == 0) zero_seen = 1;
    end
    return zero_seen;
  endfunction

  function automatic gso_result_t predict_cmd(logic [1:0] m, logic [9:0] idx,
                                             logic signed [31:0] val);
    gso_result_t r;
    r = '0;
    if (m == ModeWrite || m == ModeRun || m == ModeRead) begin
      if (!dims_ok()) begin
        r.status = StBadSize;
      end else if (m == ModeRun) begin
        r.status = orthonormalize() ? StZeroNorm : StOk;
      end else if (idx >= row_len_q * row_count_q) begin
        r.status = StBadIndex;
      end else if (m == ModeWrite) begin
        mat_model[idx] = val;
      end else begin
        r.read_value = mat_model[idx];
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    gso_result_t exp_r;
    if (!rst_ni) begin
      row_len_q    <= 64;
      row_count_q  <= 16;
      layout_q     <= 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      result_queue.delete();
    end else begin
      if (done_i) begin
        if (result_queue.size() == 0) begin
          $display("%0t: unexpected result beat read_value=%h status=%0d",
                   $time, read_value_i, status_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = result_queue.pop_front();
          if (exp_r.read_value !== read_value_i || exp_r.status !== status_i) begin
            $display("%0t: mismatch expected read_value=%h status=%0d",
                     $time, exp_r.read_value, exp_r.status);
            $display("%0t:          actual   read_value=%h status=%0d",
                     $time, read_value_i, status_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgRowLen:   row_len_q   <= cfg_data_i;
          CfgRowCount: row_count_q <= cfg_data_i;
          CfgLayout:   layout_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (start_i && !busy_i)
        result_queue.push_back(predict_cmd(mode_i, index_i, value_i));
      pending_o <= result_queue.size();
    end
  end
endmodule

>>> tb/sv/tb_top.sv
// Testbench top for gram_schmidt_orthonormalizer_core: clock, reset, command and
// config stimulus, watchdog and verdict. Depends on gso_pkg and gso_checker.
`timescale 1ns / 1ps
module tb_top;
  import gso_pkg::*;

  localparam logic [1:0] ModeIdle = 2'd3;
  localparam logic [1:0] CfgSpare = 2'd3;
  localparam int         StallLimit = 400000;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               start = 0;
  logic               busy;
  logic [1:0]         mode_i = '0;
  logic [9:0]         index_i = '0;
  logic signed [31:0] value_i = '0;
  logic               done_o;
  logic signed [31:0] read_value_o;
  logic [1:0]         status_o;
  logic               cfg_valid_i = 0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [6:0]         cfg_data_i = '0;
  int                 fail_count;
  int                 pending;
  int                 stall_cnt = 0;
  int                 n_items, n_runs, n_phases;

  always #4 clk_i = ~clk_i;

  gram_schmidt_orthonormalizer_core dut (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .index_i, .value_i,
    .done_o, .read_value_o, .status_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  gso_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .mode_i, .index_i, .value_i,
    .done_i(done_o), .read_value_i(read_value_o), .status_i(status_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("[gram_schmidt_orthonormalizer_core] ERROR");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $signed($urandom_range(0, 32'h03ff_ffff)) - 32'sh0200_0000;
    if (r < 80) return $urandom;
    if (r < 88) return '0;
    if (r < 94) return 32'sh7fffffff;
    return 32'sh80000000;
  endfunction

  // Issue one command beat; leaves start high at the following falling edge.
  task automatic send_cmd(logic [1:0] m, logic [9:0] idx, logic signed [31:0] val,
                          int gap);
    if (gap > 0) begin
      start = 0;
      repeat (gap) @(negedge clk_i);
    end
    mode_i  = m;
    index_i = idx;
    value_i = val;
    start   = 1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    n_items++;
    if (m == ModeRun) n_runs++;
  endtask

  task automatic wait_idle();
    start = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] ci, logic [6:0] d);
    cfg_index_i = ci;
    cfg_data_i  = d;
    cfg_valid_i = 1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 0;
  endtask

  task automatic set_shape(int rl, int rc, bit lay);
    wait_idle();
    write_cfg(CfgRowLen, rl[6:0]);
    write_cfg(CfgRowCount, rc[6:0]);
    write_cfg(CfgLayout, {6'd0, lay});
    n_phases++;
  endtask

  // Fill the active region, then a random mix of writes, reads, runs and unused commands, some out of range.
  task automatic random_phase(int rl, int rc, bit lay, int n_ops);
    int sz, r;
    set_shape(rl, rc, lay);
    sz = rl * rc;
    for (int e = 0; e < sz; e++) send_cmd(ModeWrite, e[9:0], pick_value(), pick_gap());
    for (int n = 0; n < n_ops; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40)
        send_cmd(ModeWrite, 10'($urandom_range(0, sz - 1)), pick_value(), pick_gap());
      else if (r < 70)
        send_cmd(ModeRead, 10'($urandom_range(0, sz - 1)), $urandom, pick_gap());
      else if (r < 82)
        send_cmd(ModeRun, 10'($urandom), $urandom, pick_gap());
      else if (r < 90)
        send_cmd(ModeRead, 10'($urandom_range(sz, 1023)), $urandom, pick_gap());
      else if (r < 96)
        send_cmd(ModeWrite, 10'($urandom_range(sz, 1023)), $urandom, pick_gap());
      else
        send_cmd(ModeIdle, 10'($urandom), $urandom, pick_gap());
    end
  endtask

  initial begin
    int rl, rc;
    n_items = 0;
    n_runs = 0;
    n_phases = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed: unused mode at reset shape, then a 2x2 matrix with extremes.
    send_cmd(ModeIdle, 10'h3ff, 32'sh7fffffff, 0);
    set_shape(2, 2, 0);
    send_cmd(ModeWrite, 10'd0, 32'sh7fffffff, 0);
    send_cmd(ModeWrite, 10'd1, 32'sh80000000, 0);
    send_cmd(ModeWrite, 10'd2, 32'sh0100_0000, 0);
    send_cmd(ModeWrite, 10'd3, -32'sh0100_0000, 0);
    send_cmd(ModeRead, 10'd1, 32'sh0, 0);
    send_cmd(ModeRead, 10'h3ff, 32'sh0, 0);
    send_cmd(ModeWrite, 10'h3ff, 32'sh1234_5678, 0);
    send_cmd(ModeRun, 10'd0, 32'sh0, 0);
    send_cmd(ModeRead, 10'd0, 32'sh0, 1);
    send_cmd(ModeRead, 10'd3, 32'sh0, 0);
    // Second vector equal to the first: it collapses to zero norm.
    send_cmd(ModeWrite, 10'd0, 32'sh0100_0000, 0);
    send_cmd(ModeWrite, 10'd1, 32'sh0, 0);
    send_cmd(ModeWrite, 10'd2, 32'sh0100_0000, 0);
    send_cmd(ModeWrite, 10'd3, 32'sh0, 0);
    send_cmd(ModeRun, 10'd0, 32'sh0, 0);
    send_cmd(ModeRead, 10'd2, 32'sh0, 0);
    wait_idle();
    write_cfg(CfgSpare, 7'h55);
    write_cfg(CfgLayout, 7'h7f);
    send_cmd(ModeRun, 10'd0, 32'sh0, 0);
    send_cmd(ModeRead, 10'd0, 32'sh0, 0);
    // Bad sizes: zero, above the maximum, product too large.
    set_shape(0, 2, 0);
    send_cmd(ModeWrite, 10'd0, 32'sh1, 0);
    send_cmd(ModeRun, 10'd0, 32'sh0, 0);
    set_shape(127, 1, 1);
    send_cmd(ModeRead, 10'd0, 32'sh0, 0);
    set_shape(64, 64, 0);
    send_cmd(ModeRun, 10'd0, 32'sh0, 0);
    send_cmd(ModeIdle, 10'd0, 32'sh0, 0);

    // Random phases, extremes of the shape among them.
    random_phase(64, 1, 0, 25);
    random_phase(64, 1, 1, 12);
    random_phase(1, 64, 0, 12);
    random_phase(1, 64, 1, 25);
    random_phase(1, 1, 0, 20);
    random_phase(16, 8, 0, 30);
    random_phase(8, 8, 1, 30);
    for (int p = 0; p < 4; p++) begin
      rl = $urandom_range(1, 8);
      rc = $urandom_range(1, 8);
      random_phase(rl, rc, $urandom_range(0, 1), 30);
    end

    wait_idle();
    repeat (20) @(negedge clk_i);
    $display("Ran %0d commands (%0d orthonormalize runs) over %0d matrix shapes,",
             n_items, n_runs, n_phases);
    $display("both layouts, bad sizes, out of range indexes and zero norm vectors.");
    if (fail_count == 0 && pending == 0) begin
      $display("[gram_schmidt_orthonormalizer_core] OK");
    end else begin
      $display("[gram_schmidt_orthonormalizer_core] ERROR");
    end
    $finish;
  end
endmodule
